/* rtl/rcfp_pkg.sv */
// shared types and constants for the rc channel frame parser
package rcfp_pkg;

  localparam logic [7:0] LEN_BYTE      = 8'h20;
  localparam logic [7:0] CMD_BYTE      = 8'h40;
  localparam logic [4:0] POS_CMD       = 5'd1;
  localparam logic [4:0] POS_CKSUM_LO  = 5'd30;
  localparam logic [4:0] POS_LAST      = 5'd31;
  localparam int unsigned WORD_AW      = 4;
  localparam int unsigned RAM_AW       = WORD_AW + 1;
  localparam int unsigned RAM_DEPTH    = 1 << RAM_AW;
  localparam int unsigned IDX_W        = 4;

  typedef struct packed {
    logic err;
    logic bank;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_RD   = 3'b010,
    BK_DATA = 3'b100
  } back_state_e;

endpackage

/* rtl/rcfp_ram.sv */
// generic single-write single-read ram with registered read data
module rcfp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rcfp_queue.sv */
// two-entry job queue between the byte front end and the result back end
module rcfp_queue import rcfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_job_i;
    end
  end

  assign head_o  = slot_q[rptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

/* rtl/rcfp_front.sv */
// front end: header hunt, frame capture into the ram, checksum and frame judgement
module rcfp_front import rcfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        rx_byte_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              ram_we_o,
  output logic [RAM_AW-1:0] ram_waddr_o,
  output logic [15:0]       ram_wdata_o,
  output logic              push_o,
  output job_t              push_job_o,
  input  logic              queue_full_i,
  input  release_t          release_i
);

  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  even_q;
  logic [7:0]  cmd_q;
  logic [7:0]  ck_lo_q;
  logic        wr_bank_q, wr_bank_d;
  logic [1:0]  busy_q, busy_d;
  logic        take;
  logic        frame_end;
  logic        cksum_bad;

  assign in_ready_o = !queue_full_i && !busy_q[wr_bank_q];
  assign take       = in_valid_i && in_ready_o && (pos_q != 5'd0 || rx_byte_i == LEN_BYTE);
  assign frame_end  = take && (pos_q == POS_LAST);
  assign cksum_bad  = ({rx_byte_i, ck_lo_q} != ~sum_q);

  // bytes land in pairs, one ram word per channel-sized slot
  assign ram_we_o    = take && pos_q[0];
  assign ram_waddr_o = {wr_bank_q, pos_q[4:1]};
  assign ram_wdata_o = {rx_byte_i, even_q};

  assign push_o          = frame_end && (cmd_q == CMD_BYTE);
  assign push_job_o.err  = cksum_bad;
  assign push_job_o.bank = wr_bank_q;

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    wr_bank_d = wr_bank_q;
    busy_d    = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (take) begin
      if (pos_q < POS_CKSUM_LO) begin
        sum_d = sum_q + {8'd0, rx_byte_i};
      end
      pos_d = pos_q + 5'd1;
    end
    if (frame_end) begin
      pos_d = 5'd0;
      sum_d = 16'd0;
    end
    // a good frame keeps its bank until the back end has read it out
    if (push_o && !cksum_bad) begin
      busy_d[wr_bank_q] = 1'b1;
      wr_bank_d         = ~wr_bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 5'd0;
      sum_q     <= 16'd0;
      wr_bank_q <= 1'b0;
      busy_q    <= 2'b00;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !pos_q[0]) begin
      even_q <= rx_byte_i;
    end
    if (take && pos_q == POS_CMD) begin
      cmd_q <= rx_byte_i;
    end
    if (take && pos_q == POS_CKSUM_LO) begin
      ck_lo_q <= rx_byte_i;
    end
  end

endmodule

/* rtl/rcfp_back.sv */
// back end: turns queued frame jobs into channel or error results
module rcfp_back import rcfp_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              ram_re_o,
  output logic [RAM_AW-1:0] ram_raddr_o,
  input  logic [15:0]       ram_rdata_i,
  output release_t          release_o,
  output logic              status_o,
  output logic [IDX_W-1:0]  channel_index_o,
  output logic [15:0]       channel_value_o,
  output logic              last_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNEL_COUNT - 1);

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             bank_q, bank_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             load_err;
  logic             load_ch;
  logic             status_q;
  logic [IDX_W-1:0] index_q;
  logic [15:0]      value_q;
  logic             last_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    bank_d   = bank_q;
    pop_o    = 1'b0;
    ram_re_o = 1'b0;
    load_err = 1'b0;
    load_ch  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (head_i.err) begin
            if (out_free) begin
              load_err = 1'b1;
              pop_o    = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            bank_d  = head_i.bank;
            idx_d   = '0;
            state_d = BK_RD;
          end
        end
      end
      BK_RD: begin
        ram_re_o = 1'b1;
        state_d  = BK_DATA;
      end
      BK_DATA: begin
        if (out_free) begin
          load_ch = 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = BK_RD;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // channel k sits in word k+1, the word after the length and command bytes
  assign ram_raddr_o = {bank_q, WORD_AW'(idx_q + IDX_W'(1))};

  assign release_o.valid = load_ch && (idx_q == LAST_IDX);
  assign release_o.bank  = bank_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_err || load_ch) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_err) begin
      status_q <= 1'b1;
      index_q  <= '0;
      value_q  <= 16'd0;
      last_q   <= 1'b1;
    end else if (load_ch) begin
      status_q <= 1'b0;
      index_q  <= idx_q;
      value_q  <= ram_rdata_i;
      last_q   <= (idx_q == LAST_IDX);
    end
  end

  assign status_o        = status_q;
  assign channel_index_o = index_q;
  assign channel_value_o = value_q;
  assign last_o          = last_q;
  assign out_valid_o     = out_valid_q;

endmodule

/* rtl/rc_channel_frame_parser.sv */
// top level of the rc channel frame parser: front end, job queue, frame ram, back end
//
// Input channel: one received serial byte per request on rx_byte_i with
// in_valid_i / in_ready_o. Bytes are dropped until the length byte 0x20,
// then a 32-byte frame is gathered.
// Output channel: status_o, channel_index_o, channel_value_o, last_o with
// out_valid_o / out_ready_i, held in an output register.
// A frame with a wrong command byte gives no request; a checksum mismatch
// gives one error request; a good frame gives CHANNEL_COUNT channel
// requests in index order, each after its own ram read, as the single ram
// read port delivers one 16-bit word per read-and-load step.
// Frames are stored in two ram banks; frames with a right command byte wait
// in a two-entry job queue, so the next frame can be received while results drain.
// in_ready_o drops while the job queue is full or the bank to be written
// still holds a frame not yet read out; a stalled receiver therefore backs
// up into the byte channel.
// Reset puts the parser back into header hunt with the queue empty.
module rc_channel_frame_parser import rcfp_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             status_o,
  output logic [IDX_W-1:0] channel_index_o,
  output logic [15:0]      channel_value_o,
  output logic             last_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [15:0]       ram_rdata;
  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              head;
  logic              empty;
  logic              full;
  release_t          release_s;

  rcfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .push_o       (push),
    .push_job_o   (push_job),
    .queue_full_i (full),
    .release_i    (release_s)
  );

  rcfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  rcfp_ram #(
    .WIDTH (16),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rcfp_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .release_o       (release_s),
    .status_o        (status_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_o          (last_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule
